// ===== design/mae_pkg.sv =====
// ----------------------------------------------------------------------------
// mae_pkg
// Shared types and constants of the matrix arithmetic engine.
// ----------------------------------------------------------------------------
package mae_pkg;

  localparam int MAX_DIM = 8;
  localparam int DATA_W  = 32;
  localparam int SZ_W    = 8;
  localparam int REG_W   = 4;

  typedef logic [DATA_W-1:0] data_t;
  typedef logic [SZ_W-1:0]   size_t;
  typedef logic [REG_W-1:0]  dim_t;

  localparam logic [3:0] OP_WRITE = 4'd0;
  localparam logic [3:0] OP_READ  = 4'd1;
  localparam logic [3:0] OP_ADD   = 4'd2;
  localparam logic [3:0] OP_SUB   = 4'd3;
  localparam logic [3:0] OP_LOADB = 4'd4;
  localparam logic [3:0] OP_MUL   = 4'd5;
  localparam logic [3:0] OP_SCALE = 4'd6;
  localparam logic [3:0] OP_DIV   = 4'd7;
  localparam logic [3:0] OP_NEG   = 4'd8;
  localparam logic [3:0] OP_ABS   = 4'd9;
  localparam logic [3:0] OP_CMP   = 4'd10;

  localparam logic [1:0] ERR_OK    = 2'd0;
  localparam logic [1:0] ERR_INDEX = 2'd1;
  localparam logic [1:0] ERR_DIV0  = 2'd2;
  localparam logic [1:0] ERR_SIZE  = 2'd3;

  localparam logic [1:0] REG_ROWS   = 2'd0;
  localparam logic [1:0] REG_COLS   = 2'd1;
  localparam logic [1:0] REG_OTHERS = 2'd2;

  typedef struct packed {
    logic  start;
    data_t dividend;
    data_t divisor;
  } div_req_t;

  typedef struct packed {
    logic  done;
    data_t quotient;
  } div_rsp_t;

endpackage

// ===== design/mae_ram.sv =====
// ----------------------------------------------------------------------------
// mae_ram
// Generic simple dual-port RAM with one write port and a registered read.
// ----------------------------------------------------------------------------
module mae_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== design/mae_div.sv =====
// ----------------------------------------------------------------------------
// mae_div
// Unsigned restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module mae_div (
  input  logic              clk,
  input  logic              rst_n,
  input  mae_pkg::div_req_t req,
  output mae_pkg::div_rsp_t rsp
);

  localparam int CW = $clog2(mae_pkg::DATA_W + 1);

  logic                      busy_r, busy_nxt;
  logic [CW-1:0]             cnt_r, cnt_nxt;
  mae_pkg::data_t            dvd_r, dvd_nxt;
  mae_pkg::data_t            dvs_r, dvs_nxt;
  logic [mae_pkg::DATA_W:0]  rem_r, rem_nxt;
  logic                      done_r, done_nxt;
  logic [mae_pkg::DATA_W:0]  rem_sh;

  always_comb begin
    busy_nxt = busy_r;
    cnt_nxt  = cnt_r;
    dvd_nxt  = dvd_r;
    dvs_nxt  = dvs_r;
    rem_nxt  = rem_r;
    done_nxt = 1'b0;
    rem_sh   = {rem_r[mae_pkg::DATA_W-1:0], dvd_r[mae_pkg::DATA_W-1]};
    if (req.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      dvd_nxt  = req.dividend;
      dvs_nxt  = req.divisor;
      rem_nxt  = '0;
    end else if (busy_r) begin
      if (rem_sh >= {1'b0, dvs_r}) begin
        rem_nxt = rem_sh - {1'b0, dvs_r};
        dvd_nxt = {dvd_r[mae_pkg::DATA_W-2:0], 1'b1};
      end else begin
        rem_nxt = rem_sh;
        dvd_nxt = {dvd_r[mae_pkg::DATA_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == CW'(mae_pkg::DATA_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    dvd_r <= dvd_nxt;
    dvs_r <= dvs_nxt;
    rem_r <= rem_nxt;
  end

  assign rsp.done     = done_r;
  assign rsp.quotient = dvd_r;

endmodule

// ===== design/matrix_arith_engine_top.sv =====
// ----------------------------------------------------------------------------
// matrix_arith_engine_top
// Per-entry ops read the entry of A and then write or report it; load B and errors
// complete from idle. Scale, negate and abs read and rewrite each entry of A in
// turn; divide waits on the serial divider for each entry of A.
// A multiply forms each dot product in the single MAC unit, then copies the product
// into A entry by entry. One transaction at a time; results cannot be stalled.
// Reset clears A through per-entry valid bits at once, with no clearing pass.
// ----------------------------------------------------------------------------
module matrix_arith_engine_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [3:0]  in_operation,
  input  logic [5:0]  in_entry_index,
  input  logic [31:0] in_operand_value,
  input  logic        in_last_entry,
  output logic        out_strobe,
  output logic [31:0] out_read_value,
  output logic        out_equal_flag,
  output logic [1:0]  out_error_code,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [3:0]  cfg_wdata
);

  localparam int DEPTH = mae_pkg::MAX_DIM * mae_pkg::MAX_DIM;
  localparam int AW    = $clog2(DEPTH);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_ENT  = 3'd1;
  localparam logic [2:0] S_WRD  = 3'd2;
  localparam logic [2:0] S_WEX  = 3'd3;
  localparam logic [2:0] S_WDIV = 3'd4;
  localparam logic [2:0] S_MUL  = 3'd5;
  localparam logic [2:0] S_COPY = 3'd6;

  logic [2:0]           state_r, state_nxt;
  logic [3:0]           op_r, op_nxt;
  logic [5:0]           idx_r, idx_nxt;
  mae_pkg::data_t       x_r, x_nxt;
  logic                 last_r, last_nxt;
  mae_pkg::dim_t        row_r, row_nxt, cw_r, cw_nxt, oc_r, oc_nxt;
  logic                 match_r, match_nxt;
  logic [DEPTH-1:0]     vld_r, vld_nxt;
  mae_pkg::size_t       rq_r, rq_nxt;
  mae_pkg::size_t       cnt_r, cnt_nxt;
  logic                 sgn_r, sgn_nxt;
  mae_pkg::dim_t        i_r, i_nxt, j_r, j_nxt, k_r, k_nxt;
  mae_pkg::size_t       aa_r, aa_nxt, ab_r, ab_nxt, bb_r, bb_nxt, pa_r, pa_nxt;
  logic                 iss_r, iss_nxt;
  logic                 s1v_r, s1v_nxt, s1l_r, s1l_nxt, s2v_r, s2v_nxt, s2l_r, s2l_nxt;
  mae_pkg::data_t       prod_r, prod_nxt, acc_r, acc_nxt;
  logic                 cv_r, cv_nxt;
  mae_pkg::size_t       ca_r, ca_nxt;
  logic                 ostb_r, ostb_nxt, oeq_r, oeq_nxt;
  mae_pkg::data_t       orv_r, orv_nxt;
  logic [1:0]           oerr_r, oerr_nxt;

  logic                 a_we, b_we, p_we;
  logic [AW-1:0]        a_wa, a_ra, b_wa, b_ra, p_wa, p_ra;
  mae_pkg::data_t       a_wd, b_wd, p_wd, a_q, b_q, p_q, a_eff, v, sum;
  mae_pkg::size_t       n_sz, pb_sz, pr_sz, idx_sz;
  logic                 ok_a, ok_b, hit, m, adv, p_wr;
  mae_pkg::div_req_t    dreq;
  mae_pkg::div_rsp_t    drsp;

  mae_ram #(.WIDTH(mae_pkg::DATA_W), .DEPTH(DEPTH)) u_a_ram (
    .clk(clk), .we(a_we), .waddr(a_wa), .wdata(a_wd), .raddr(a_ra), .rdata(a_q)
  );
  mae_ram #(.WIDTH(mae_pkg::DATA_W), .DEPTH(DEPTH)) u_b_ram (
    .clk(clk), .we(b_we), .waddr(b_wa), .wdata(b_wd), .raddr(b_ra), .rdata(b_q)
  );
  mae_ram #(.WIDTH(mae_pkg::DATA_W), .DEPTH(DEPTH)) u_p_ram (
    .clk(clk), .we(p_we), .waddr(p_wa), .wdata(p_wd), .raddr(p_ra), .rdata(p_q)
  );
  mae_div u_div (.clk(clk), .rst_n(rst_n), .req(dreq), .rsp(drsp));

  assign n_sz   = mae_pkg::SZ_W'(row_r * cw_r);
  assign pb_sz  = mae_pkg::SZ_W'(cw_r * oc_r);
  assign pr_sz  = mae_pkg::SZ_W'(row_r * oc_r);
  assign idx_sz = mae_pkg::SZ_W'(in_entry_index);
  assign ok_a   = (idx_sz < n_sz) && (int'(in_entry_index) < DEPTH);
  assign ok_b   = (idx_sz < pb_sz) && (int'(in_entry_index) < DEPTH);
  assign a_eff  = vld_r[rq_r[AW-1:0]] ? a_q : '0;

  always_comb begin
    state_nxt = state_r;  op_nxt = op_r;  idx_nxt = idx_r;  x_nxt = x_r;
    last_nxt = last_r;  row_nxt = row_r;  cw_nxt = cw_r;  oc_nxt = oc_r;
    match_nxt = match_r;  vld_nxt = vld_r;  rq_nxt = rq_r;  cnt_nxt = cnt_r;
    sgn_nxt = sgn_r;  i_nxt = i_r;  j_nxt = j_r;  k_nxt = k_r;
    aa_nxt = aa_r;  ab_nxt = ab_r;  bb_nxt = bb_r;  pa_nxt = pa_r;
    iss_nxt = iss_r;  s1v_nxt = 1'b0;  s1l_nxt = s1l_r;  s2v_nxt = 1'b0;
    s2l_nxt = s2l_r;  prod_nxt = prod_r;  acc_nxt = acc_r;  cv_nxt = 1'b0;
    ca_nxt = ca_r;  ostb_nxt = 1'b0;  orv_nxt = orv_r;  oeq_nxt = oeq_r;
    oerr_nxt = oerr_r;
    a_we = 1'b0;  a_wa = '0;  a_wd = '0;  a_ra = '0;
    b_we = 1'b0;  b_wa = '0;  b_wd = '0;  b_ra = '0;
    p_we = 1'b0;  p_wa = '0;  p_wd = '0;  p_ra = '0;
    dreq.start = 1'b0;  dreq.dividend = '0;  dreq.divisor = '0;
    v = '0;  sum = '0;  hit = 1'b0;  m = 1'b0;  adv = 1'b0;  p_wr = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (start) begin
          op_nxt = in_operation;  idx_nxt = in_entry_index;
          x_nxt = in_operand_value;  last_nxt = in_last_entry;
          ostb_nxt = 1'b1;  orv_nxt = '0;  oeq_nxt = 1'b0;
          oerr_nxt = mae_pkg::ERR_OK;
          case (in_operation)
            mae_pkg::OP_WRITE, mae_pkg::OP_READ, mae_pkg::OP_ADD,
            mae_pkg::OP_SUB, mae_pkg::OP_CMP: begin
              if (ok_a) begin
                ostb_nxt = 1'b0;
                a_ra = in_entry_index[AW-1:0];
                rq_nxt = idx_sz;
                state_nxt = S_ENT;
              end else begin
                oerr_nxt = mae_pkg::ERR_INDEX;
                if (in_operation == mae_pkg::OP_CMP) begin
                  match_nxt = 1'b0;
                  if (in_last_entry) begin
                    match_nxt = 1'b1;
                  end
                end
              end
            end
            mae_pkg::OP_LOADB: begin
              if (ok_b) begin
                b_we = 1'b1;
                b_wa = in_entry_index[AW-1:0];
                b_wd = in_operand_value;
              end else begin
                oerr_nxt = mae_pkg::ERR_INDEX;
              end
            end
            mae_pkg::OP_MUL: begin
              if (int'(n_sz) > DEPTH || int'(pb_sz) > DEPTH) begin
                oerr_nxt = mae_pkg::ERR_INDEX;
              end else if (int'(pr_sz) > DEPTH) begin
                oerr_nxt = mae_pkg::ERR_SIZE;
              end else begin
                ostb_nxt = 1'b0;
                i_nxt = '0;  j_nxt = '0;  k_nxt = '0;
                aa_nxt = '0;  ab_nxt = '0;  bb_nxt = '0;  pa_nxt = '0;
                acc_nxt = '0;  iss_nxt = 1'b1;  cnt_nxt = '0;
                state_nxt = (row_r == '0 || oc_r == '0) ? S_COPY : S_MUL;
              end
            end
            mae_pkg::OP_SCALE, mae_pkg::OP_DIV, mae_pkg::OP_NEG,
            mae_pkg::OP_ABS: begin
              if (int'(n_sz) > DEPTH) begin
                oerr_nxt = mae_pkg::ERR_INDEX;
              end else if (in_operation == mae_pkg::OP_DIV && in_operand_value == '0) begin
                oerr_nxt = mae_pkg::ERR_DIV0;
              end else begin
                ostb_nxt = 1'b0;
                cnt_nxt = '0;
                state_nxt = S_WRD;
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_ENT: begin
        ostb_nxt = 1'b1;
        state_nxt = S_IDLE;
        case (op_r)
          mae_pkg::OP_WRITE: begin
            a_we = 1'b1;  a_wa = idx_r[AW-1:0];  a_wd = x_r;
          end
          mae_pkg::OP_READ: begin
            orv_nxt = a_eff;
          end
          mae_pkg::OP_ADD: begin
            a_we = 1'b1;  a_wa = idx_r[AW-1:0];  a_wd = a_eff + x_r;
          end
          mae_pkg::OP_SUB: begin
            a_we = 1'b1;  a_wa = idx_r[AW-1:0];  a_wd = a_eff - x_r;
          end
          default: begin
            hit = (a_eff == x_r);
            m = match_r && hit;
            match_nxt = m;
            if (last_r) begin
              oeq_nxt = m;
              match_nxt = 1'b1;
            end
          end
        endcase
      end
      S_WRD: begin
        if (cnt_r == n_sz) begin
          ostb_nxt = 1'b1;
          state_nxt = S_IDLE;
        end else begin
          a_ra = cnt_r[AW-1:0];
          rq_nxt = cnt_r;
          state_nxt = S_WEX;
        end
      end
      S_WEX: begin
        case (op_r)
          mae_pkg::OP_SCALE: v = mae_pkg::DATA_W'(a_eff * x_r);
          mae_pkg::OP_NEG:   v = '0 - a_eff;
          mae_pkg::OP_ABS:   v = a_eff[mae_pkg::DATA_W-1] ? ('0 - a_eff) : a_eff;
          default:           v = a_eff;
        endcase
        if (op_r == mae_pkg::OP_DIV) begin
          dreq.start = 1'b1;
          dreq.dividend = a_eff[mae_pkg::DATA_W-1] ? ('0 - a_eff) : a_eff;
          dreq.divisor = x_r[mae_pkg::DATA_W-1] ? ('0 - x_r) : x_r;
          sgn_nxt = a_eff[mae_pkg::DATA_W-1] ^ x_r[mae_pkg::DATA_W-1];
          state_nxt = S_WDIV;
        end else begin
          a_we = 1'b1;  a_wa = cnt_r[AW-1:0];  a_wd = v;
          cnt_nxt = cnt_r + 1'b1;
          state_nxt = S_WRD;
        end
      end
      S_WDIV: begin
        if (drsp.done) begin
          a_we = 1'b1;  a_wa = cnt_r[AW-1:0];
          a_wd = sgn_r ? ('0 - drsp.quotient) : drsp.quotient;
          cnt_nxt = cnt_r + 1'b1;
          state_nxt = S_WRD;
        end
      end
      S_MUL: begin
        if (iss_r) begin
          if (cw_r == '0) begin
            p_wr = 1'b1;
            adv = 1'b1;
          end else begin
            a_ra = aa_r[AW-1:0];
            b_ra = bb_r[AW-1:0];
            rq_nxt = aa_r;
            s1v_nxt = 1'b1;
            s1l_nxt = (k_r == cw_r - 1'b1);
            if (k_r == cw_r - 1'b1) begin
              iss_nxt = 1'b0;
              k_nxt = '0;
            end else begin
              k_nxt = k_r + 1'b1;
              aa_nxt = aa_r + 1'b1;
              bb_nxt = bb_r + mae_pkg::SZ_W'(oc_r);
            end
          end
        end
        if (s1v_r) begin
          prod_nxt = mae_pkg::DATA_W'(a_eff * b_q);
          s2v_nxt = 1'b1;
          s2l_nxt = s1l_r;
        end
        if (s2v_r) begin
          sum = acc_r + prod_r;
          if (s2l_r) begin
            p_wr = 1'b1;
            acc_nxt = '0;
            adv = 1'b1;
          end else begin
            acc_nxt = sum;
          end
        end
        if (p_wr) begin
          p_we = 1'b1;  p_wa = pa_r[AW-1:0];  p_wd = sum;
        end
        if (adv) begin
          pa_nxt = pa_r + 1'b1;
          iss_nxt = 1'b1;
          if (j_r == oc_r - 1'b1) begin
            j_nxt = '0;
            bb_nxt = '0;
            if (i_r == row_r - 1'b1) begin
              iss_nxt = 1'b0;
              cnt_nxt = '0;
              state_nxt = S_COPY;
            end else begin
              i_nxt = i_r + 1'b1;
              ab_nxt = ab_r + mae_pkg::SZ_W'(cw_r);
              aa_nxt = ab_r + mae_pkg::SZ_W'(cw_r);
            end
          end else begin
            j_nxt = j_r + 1'b1;
            aa_nxt = ab_r;
            bb_nxt = mae_pkg::SZ_W'(j_r) + 1'b1;
          end
        end
      end
      S_COPY: begin
        if (cnt_r != pr_sz) begin
          p_ra = cnt_r[AW-1:0];
          cv_nxt = 1'b1;
          ca_nxt = cnt_r;
          cnt_nxt = cnt_r + 1'b1;
        end else if (!cv_r) begin
          cw_nxt = oc_r;
          ostb_nxt = 1'b1;
          state_nxt = S_IDLE;
        end
        if (cv_r) begin
          a_we = 1'b1;  a_wa = ca_r[AW-1:0];  a_wd = p_q;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    if (a_we) begin
      vld_nxt[a_wa] = 1'b1;
    end

    if (cfg_we) begin
      case (cfg_index)
        mae_pkg::REG_ROWS: row_nxt = cfg_wdata;
        mae_pkg::REG_COLS: cw_nxt = cfg_wdata;
        mae_pkg::REG_OTHERS: oc_nxt = cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      row_r   <= 4'd3;
      cw_r    <= 4'd3;
      oc_r    <= 4'd3;
      match_r <= 1'b1;
      vld_r   <= '0;
      iss_r   <= 1'b0;
      s1v_r   <= 1'b0;
      s2v_r   <= 1'b0;
      cv_r    <= 1'b0;
      ostb_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      row_r   <= row_nxt;
      cw_r    <= cw_nxt;
      oc_r    <= oc_nxt;
      match_r <= match_nxt;
      vld_r   <= vld_nxt;
      iss_r   <= iss_nxt;
      s1v_r   <= s1v_nxt;
      s2v_r   <= s2v_nxt;
      cv_r    <= cv_nxt;
      ostb_r  <= ostb_nxt;
    end
    op_r   <= op_nxt;    idx_r <= idx_nxt;  x_r   <= x_nxt;   last_r <= last_nxt;
    rq_r   <= rq_nxt;    cnt_r <= cnt_nxt;  sgn_r <= sgn_nxt;
    i_r    <= i_nxt;     j_r   <= j_nxt;    k_r   <= k_nxt;
    aa_r   <= aa_nxt;    ab_r  <= ab_nxt;   bb_r  <= bb_nxt;  pa_r <= pa_nxt;
    s1l_r  <= s1l_nxt;   s2l_r <= s2l_nxt;  prod_r <= prod_nxt;
    acc_r  <= acc_nxt;   ca_r  <= ca_nxt;
    orv_r  <= orv_nxt;   oeq_r <= oeq_nxt;  oerr_r <= oerr_nxt;
  end

  assign busy           = (state_r != S_IDLE);
  assign out_strobe     = ostb_r;
  assign out_read_value = orv_r;
  assign out_equal_flag = oeq_r;
  assign out_error_code = oerr_r;

endmodule
